// ===== design/fpr_pkg.sv =====
package fpr_pkg;

    // Fixed field widths of the result transaction
    localparam int SLOT_W  = 4;
    localparam int EVPG_W  = 16;
    localparam int FAULT_W = 32;
    localparam int CFG_W   = 5;

    // Result tdata layout, lowest bit first
    localparam int SLOT_LSB   = 0;
    localparam int EVV_LSB    = SLOT_LSB + SLOT_W;
    localparam int EVPG_LSB   = EVV_LSB + 1;
    localparam int FAULT_LSB  = EVPG_LSB + EVPG_W;
    localparam int RES_BITS   = FAULT_LSB + FAULT_W;
    localparam int RES_TDATA_W = ((RES_BITS + 7) / 8) * 8;

    // Default sizes
    localparam int DEF_FRAMES    = 16;
    localparam int DEF_PAGE_BITS = 16;

    // Register map: frames_in_use at byte address zero
    localparam logic REG_FRAMES_IN_USE = 1'b0;
    localparam logic [CFG_W-1:0] FRAMES_IN_USE_RST = 5'd16;

    localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

    // Control handed to each cell
    typedef struct packed {
        logic active;   // cell index below the active frame count
        logic wr;       // load the reference page into this cell
    } cell_ctl_t;

    // Status returned by each cell
    typedef struct packed {
        logic first_hit; // lowest matching cell
        logic valid;     // cell holds a resident page
    } cell_stat_t;

endpackage

// ===== design/fifo_page_replacement.sv =====
// FIFO page replacement unit.
//
// Input stream (s_*): one page reference per transaction, page number in
// the low PAGE_BITS of s_tdata. Result stream (m_*): one transaction per
// reference, m_tuser = hit flag, m_tdata = slot, eviction and fault count.
//
// The resident pages sit in a row of FRAMES cells. Each cell compares the
// broadcast page against its own entry; a found flag ripples from cell to
// cell so the lowest matching frame wins. On a miss the page is loaded into
// the cell at the fill pointer, which wraps over the active frames, and the
// saturating fault counter advances.
//
// m_tvalid rises once a reference has passed the reference register and
// the result register. Throughput: one reference per cycle unless a held
// result stalls; the resolving edge writes the cells for the next lookup.
// Reset: all frames empty, fill pointer zero, fault count zero,
// frames_in_use = 16. Stall: while m_tready is low the held result stays
// put, the pending reference waits and s_tready drops. frames_in_use (APB,
// address 0) may only be written while idle; zero acts as one frame, values
// above FRAMES act as FRAMES.
module fifo_page_replacement #(
    parameter int FRAMES    = fpr_pkg::DEF_FRAMES,
    parameter int PAGE_BITS = fpr_pkg::DEF_PAGE_BITS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // page reference stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [((PAGE_BITS+7)/8)*8-1:0]     s_tdata,  // [PAGE_BITS-1:0] page_number
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [fpr_pkg::RES_TDATA_W-1:0]    m_tdata,  // frame_slot, evicted_valid,
                                                         // evicted_page, fault_count
    output logic                               m_tuser,  // hit
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic                               paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    localparam int SW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int NW = $clog2(FRAMES + 1);

    // configuration
    logic [fpr_pkg::CFG_W-1:0] frames_reg;
    logic [NW-1:0]             n_act;
    logic                      cfg_wr;

    // reference register
    logic                      busy_reg;
    logic [PAGE_BITS-1:0]      page_reg;
    logic                      go;

    // replacement state
    logic [SW-1:0]                 fp_reg;
    logic [SW-1:0]                 fp_next;
    logic [fpr_pkg::FAULT_W-1:0]   fault_reg;
    logic [fpr_pkg::FAULT_W-1:0]   fault_next;

    // cell row
    fpr_pkg::cell_ctl_t     ctl   [FRAMES];
    fpr_pkg::cell_stat_t    stat  [FRAMES];
    logic [PAGE_BITS-1:0]   cpage [FRAMES];
    logic [FRAMES:0]        found_chain;
    logic [FRAMES-1:0]      hit_vec;

    logic                   found;
    logic [SW-1:0]          hit_slot;
    logic [SW-1:0]          fill_slot;
    logic [SW-1:0]          slot;
    logic                   ev_valid;
    logic [PAGE_BITS-1:0]   ev_page;
    logic [31:0]            slot_ext;
    logic [31:0]            evp_ext;

    // result register
    logic                               m_valid_reg;
    logic [fpr_pkg::RES_TDATA_W-1:0]    m_data_reg;
    logic                               m_hit_reg;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == fpr_pkg::REG_FRAMES_IN_USE);
    assign prdata = (paddr == fpr_pkg::REG_FRAMES_IN_USE) ?
                    32'(frames_reg) : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frames_reg <= fpr_pkg::FRAMES_IN_USE_RST;
        end else if (cfg_wr) begin
            frames_reg <= pwdata[fpr_pkg::CFG_W-1:0];
        end
    end

    // active frame count, clamped to 1..FRAMES
    always_comb begin
        if (frames_reg == '0) begin
            n_act = NW'(1);
        end else if (32'(frames_reg) > 32'(FRAMES)) begin
            n_act = NW'(FRAMES);
        end else begin
            n_act = NW'(frames_reg);
        end
    end

    // ---------------- handshakes ----------------
    assign go       = busy_reg && (!m_valid_reg || m_tready);
    assign s_tready = !busy_reg || go;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            busy_reg <= 1'b1;
        end else if (go) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            page_reg <= s_tdata[PAGE_BITS-1:0];
        end
    end

    // ---------------- cell row ----------------
    assign found_chain[0] = 1'b0;

    for (genvar i = 0; i < FRAMES; i++) begin : g_cell
        assign ctl[i].active = (32'(i) < 32'(n_act));
        assign ctl[i].wr     = go && !found && (fill_slot == SW'(i));
        assign hit_vec[i]    = stat[i].first_hit;

        fpr_cell #(
            .PAGE_BITS (PAGE_BITS)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .page_in   (page_reg),
            .ctl       (ctl[i]),
            .found_in  (found_chain[i]),
            .found_out (found_chain[i+1]),
            .stat      (stat[i]),
            .page_out  (cpage[i])
        );
    end

    assign found = found_chain[FRAMES];

    // one-hot first hit to index
    always_comb begin
        hit_slot = '0;
        for (int i = 0; i < FRAMES; i++) begin
            if (hit_vec[i]) begin
                hit_slot = hit_slot | SW'(i);
            end
        end
    end

    // fill pointer wraps to zero if the frame count shrank below it
    assign fill_slot = (32'(fp_reg) >= 32'(n_act)) ? '0 : fp_reg;
    assign fp_next   = (32'(fill_slot) + 32'd1 >= 32'(n_act)) ? '0 : SW'(fill_slot + 1'b1);

    assign ev_valid = !found && stat[fill_slot].valid;
    assign ev_page  = ev_valid ? cpage[fill_slot] : '0;
    assign slot     = found ? hit_slot : fill_slot;

    assign fault_next = (!found && fault_reg != fpr_pkg::FAULT_MAX) ?
                        fault_reg + 1'b1 : fault_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fp_reg    <= '0;
            fault_reg <= '0;
        end else if (go && !found) begin
            fp_reg    <= fp_next;
            fault_reg <= fault_next;
        end
    end

    // ---------------- result register ----------------
    assign slot_ext = 32'(slot);
    assign evp_ext  = 32'(ev_page);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (go) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (go) begin
            m_hit_reg  <= found;
            m_data_reg <= fpr_pkg::RES_TDATA_W'({
                fault_next,
                evp_ext[fpr_pkg::EVPG_W-1:0],
                ev_valid,
                slot_ext[fpr_pkg::SLOT_W-1:0]
            });
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_hit_reg;

    // ---------------- assertions ----------------
    // a hit never reports an eviction
    a_hit_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> !m_tdata[fpr_pkg::EVV_LSB] &&
            m_tdata[fpr_pkg::FAULT_LSB-1:fpr_pkg::EVPG_LSB] == '0)
        else $error("hit result carries an eviction");

    // at most one cell claims the first match
    a_one_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(hit_vec))
        else $error("more than one first-hit cell");

    // fault counter never goes backwards
    a_fault_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> fault_reg >= $past(fault_reg))
        else $error("fault counter decreased");

    // a resolved reference always yields a result next cycle
    a_go_result: assert property (@(posedge aclk) disable iff (!aresetn)
        go |=> m_tvalid)
        else $error("resolved reference produced no result");

endmodule

// ===== design/fpr_cell.sv =====
module fpr_cell #(
    parameter int PAGE_BITS = fpr_pkg::DEF_PAGE_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [PAGE_BITS-1:0]  page_in,
    input  fpr_pkg::cell_ctl_t    ctl,
    input  logic                  found_in,
    output logic                  found_out,
    output fpr_pkg::cell_stat_t   stat,
    output logic [PAGE_BITS-1:0]  page_out
);

    logic [PAGE_BITS-1:0] page_reg;
    logic                 valid_reg;
    logic                 match;

    assign match     = ctl.active && valid_reg && (page_reg == page_in);
    assign found_out = found_in | match;

    assign stat.first_hit = match & ~found_in;
    assign stat.valid     = valid_reg;
    assign page_out       = page_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctl.wr) begin
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.wr) begin
            page_reg <= page_in;
        end
    end

endmodule
